@@ rtl/assert_macros.svh @@
// Assertion helpers. Property checks are left out when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at each rising clock edge outside reset
`define SKT_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("skt: implication check failed");

// Next-cycle implication
`define SKT_ASSERT_NXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("skt: next-cycle check failed");

`else

`define SKT_ASSERT_IMP(name, clk, rst_n, pre, post)
`define SKT_ASSERT_NXT(name, clk, rst_n, pre, post)

`endif

`endif

@@ rtl/skt_pkg.sv @@
package skt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_FIND = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic signed [31:0] key;
		logic signed [31:0] entry_index;
		logic [31:0] entry_tag;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [CNT_W-1:0] slot;
		logic signed [31:0] found_index;
		logic [31:0] found_tag;
		logic status;
		logic [CNT_W-1:0] used;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] index;
		logic [31:0] tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Sequencer to RAM port
	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		entry_t wdata;
		logic re;
		logic [ADDR_W-1:0] raddr;
	} ram_cmd_t;

endpackage

@@ rtl/skt_req_if.sv @@
interface skt_req_if;
	import skt_pkg::*;

	logic valid;
	logic ready;
	logic [1:0] func;
	logic signed [31:0] key;
	logic signed [31:0] entry_index;
	logic [31:0] entry_tag;

	modport source (output valid, output func, output key, output entry_index,
		output entry_tag, input ready);
	modport sink (input valid, input func, input key, input entry_index,
		input entry_tag, output ready);
endinterface

@@ rtl/skt_rsp_if.sv @@
interface skt_rsp_if;
	import skt_pkg::*;

	logic valid;
	logic ready;
	logic hit;
	logic [CNT_W-1:0] slot;
	logic signed [31:0] found_index;
	logic [31:0] found_tag;
	logic status;
	logic [CNT_W-1:0] used;

	modport source (output valid, output hit, output slot, output found_index,
		output found_tag, output status, output used, input ready);
	modport sink (input valid, input hit, input slot, input found_index,
		input found_tag, input status, input used, output ready);
endinterface

@@ rtl/skt_ram.sv @@
module skt_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/skt_seq.sv @@
module skt_seq (
	input logic clk,
	input logic arst_n,
	input logic start,
	input skt_pkg::req_t req,
	output logic idle,
	input logic out_free,
	output logic done,
	output skt_pkg::rsp_t res,
	output skt_pkg::ram_cmd_t ram,
	input skt_pkg::entry_t rdata
);
	import skt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PROBE = 3'd1;
	localparam logic [2:0] S_CMP = 3'd2;
	localparam logic [2:0] S_SHRD = 3'd3;
	localparam logic [2:0] S_SHWR = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	logic [2:0] st_q, st_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	req_t req_q;
	logic [CNT_W-1:0] lo_q, hi_q, ptr_q, slot_q;
	logic [ADDR_W-1:0] mid_q;
	logic hit_q, status_q;
	logic signed [31:0] fidx_q;
	logic [31:0] ftag_q;
	logic [CNT_W:0] sum;
	logic [CNT_W-1:0] mid;
	logic key_lt, key_gt;

	// midpoint of the half-open interval; below hi, so it fits an address
	assign sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = sum[CNT_W:1];

	// the shared key comparators
	assign key_lt = $signed(rdata.key) < $signed(req_q.key);
	assign key_gt = $signed(rdata.key) > $signed(req_q.key);

	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		done = 1'b0;
		ram.we = 1'b0;
		ram.waddr = ptr_q[ADDR_W-1:0];
		ram.wdata = rdata;
		ram.re = 1'b0;
		ram.raddr = mid[ADDR_W-1:0];
		case (st_q)
			S_IDLE: begin
				if (start) begin
					case (req.func)
						FN_INSERT, FN_FIND: st_d = S_PROBE;
						FN_CLEAR: begin
							cnt_d = '0;
							st_d = S_FIN;
						end
						default: st_d = S_FIN;
					endcase
				end
			end
			S_PROBE: begin
				if (lo_q < hi_q) begin
					ram.re = 1'b1;
					st_d = S_CMP;
				end else if (req_q.func == FN_FIND) begin
					st_d = S_FIN;
				end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
					st_d = S_FIN;
				end else begin
					st_d = S_SHRD;
				end
			end
			S_CMP: begin
				if (!key_lt && !key_gt && req_q.func == FN_FIND) begin
					st_d = S_FIN;
				end else begin
					st_d = S_PROBE;
				end
			end
			S_SHRD: begin
				if (ptr_q > lo_q) begin
					ram.re = 1'b1;
					ram.raddr = ADDR_W'(ptr_q - 1'b1);
					st_d = S_SHWR;
				end else begin
					ram.we = 1'b1;
					ram.waddr = lo_q[ADDR_W-1:0];
					ram.wdata = '{key: req_q.key, index: req_q.entry_index,
						tag: req_q.entry_tag};
					cnt_d = cnt_q + 1'b1;
					st_d = S_FIN;
				end
			end
			S_SHWR: begin
				ram.we = 1'b1;
				st_d = S_SHRD;
			end
			S_FIN: begin
				if (out_free) begin
					done = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (start) begin
					req_q <= req;
					lo_q <= '0;
					hi_q <= cnt_q;
					hit_q <= 1'b0;
					slot_q <= '0;
					fidx_q <= '0;
					ftag_q <= '0;
					status_q <= 1'b0;
				end
			end
			S_PROBE: begin
				mid_q <= mid[ADDR_W-1:0];
				if (!(lo_q < hi_q)) begin
					slot_q <= lo_q;
					ptr_q <= cnt_q;
					if (req_q.func == FN_INSERT && cnt_q == CNT_W'(TABLE_DEPTH)) begin
						status_q <= 1'b1;
					end
				end
			end
			S_CMP: begin
				if (key_lt) begin
					lo_q <= CNT_W'(mid_q) + 1'b1;
				end else if (key_gt || req_q.func != FN_FIND) begin
					hi_q <= CNT_W'(mid_q);
				end else begin
					hit_q <= 1'b1;
					slot_q <= CNT_W'(mid_q);
					fidx_q <= rdata.index;
					ftag_q <= rdata.tag;
				end
			end
			S_SHWR: ptr_q <= ptr_q - 1'b1;
			default: ;
		endcase
	end

	assign idle = (st_q == S_IDLE);
	assign res = '{hit: hit_q, slot: slot_q, found_index: fidx_q, found_tag: ftag_q,
		status: status_q, used: cnt_q};
endmodule

@@ rtl/sorted_key_table_search_insert_core.sv @@
// Channel | Dir | Fields (one word per handshake)
// req     | in  | func, key, entry_index, entry_tag
// rsp     | out | hit, slot, found_index, found_tag, status, used
//
// Steps, accept to rsp.valid: clear or unknown func go straight to the result; find runs
// one RAM read and compare per probe until a hit or a miss, up to 9 probes over a full table.
// Insert: miss search, then one RAM read/write pair per entry moved up and the final write.
// req.ready is high only while the sequencer is idle; one word in flight at a time.
// rsp is a register: the next word is taken while a result still waits on rsp.ready.
// Reset clears the entry count, the sequencer state and rsp.valid; the table needs no clearing pass.
`include "assert_macros.svh"

module sorted_key_table_search_insert_core (
	input logic clk,
	input logic arst_n,
	skt_req_if.sink req,
	skt_rsp_if.source rsp
);
	import skt_pkg::*;

	req_t req_w;
	rsp_t res;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic idle, start, done, out_free;
	ram_cmd_t ram;
	entry_t rdata;

	assign req_w = '{func: req.func, key: req.key, entry_index: req.entry_index,
		entry_tag: req.entry_tag};
	assign req.ready = idle;
	assign start = req.valid && idle;

	// result may load when the output register is empty or draining
	assign out_free = !rsp_valid_q || rsp.ready;

	skt_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req_w),
		.idle(idle),
		.out_free(out_free),
		.done(done),
		.res(res),
		.ram(ram),
		.rdata(rdata)
	);

	// key, index and tag stored side by side
	skt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram.we),
		.waddr(ram.waddr),
		.wdata(ram.wdata),
		.re(ram.re),
		.raddr(ram.raddr),
		.rdata(rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.hit = rsp_q.hit;
	assign rsp.slot = rsp_q.slot;
	assign rsp.found_index = rsp_q.found_index;
	assign rsp.found_tag = rsp_q.found_tag;
	assign rsp.status = rsp_q.status;
	assign rsp.used = rsp_q.used;

	// a finished result never overwrites one still waiting
	`SKT_ASSERT_IMP(a_no_overwrite, clk, arst_n, done, out_free)
	// an accepted word keeps the block busy next cycle
	`SKT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, start, !idle)
	// a refused insert only ever reports a full table
	`SKT_ASSERT_IMP(a_refuse_full, clk, arst_n, rsp_valid_q && rsp_q.status,
		rsp_q.used == CNT_W'(TABLE_DEPTH))
	// table never reads and writes in the same cycle
	`SKT_ASSERT_IMP(a_ram_one_op, clk, arst_n, ram.we, !ram.re)
endmodule

@@ sim/testbench.sv @@
module testbench;
	import skt_pkg::*;

	// Watchdog: worst insert moves 255 entries, each a RAM read and write, plus
	// search and handshake stalls, over ~560 words, with plenty of margin on top.
	localparam int CYCLE_LIMIT = 1_500_000;
	// Percent of cycles in which each side idles.
	localparam int IDLE_PCT = 26;
	// Quiet cycles after the last result, longer than one full-table insert.
	localparam int TAIL_CYCLES = 600;

	localparam logic [1:0] FN_UNKNOWN = 2'd3;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	// One entry of the pending stimulus: a request word, or a drain marker
	// that holds the sender until every expected result has come back.
	typedef struct {
		bit drain;
		req_t word;
	} op_t;

	logic clk = 1'b0;
	logic arst_n;

	skt_req_if req_if();
	skt_rsp_if rsp_if();

	sorted_key_table_search_insert_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the sorted table
	logic signed [31:0] tbl_key [TABLE_DEPTH];
	logic signed [31:0] tbl_idx [TABLE_DEPTH];
	logic [31:0] tbl_tag [TABLE_DEPTH];
	int tbl_cnt = 0;

	op_t op_q[$];                    // words still to send
	rsp_t due_q[$];                  // results owed by the block, oldest first
	logic signed [31:0] key_hist[$]; // keys sent with insert, to aim finds at hits
	int words_in = 0;                // words taken by the block (rising edge)
	int words_seen = 0;              // words the sender has noticed as taken
	int err_cnt = 0;

	// Apply one word to the shadow table and return the result it owes.
	function automatic rsp_t table_step(req_t w);
		rsp_t r;
		int lo;
		int hi;
		int mid;
		int i;
		bit found;
		r = '0;
		lo = 0;
		hi = tbl_cnt;
		mid = 0;
		found = 1'b0;
		case (w.func)
		FN_INSERT: begin
			// lower bound: lands before any equal keys
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if ($signed(tbl_key[mid]) < $signed(w.key))
					lo = mid + 1;
				else
					hi = mid;
			end
			r.slot = CNT_W'(lo);
			if (tbl_cnt >= TABLE_DEPTH) begin
				// full: refused, table untouched, slot still reports the spot
				r.status = 1'b1;
			end else begin
				for (i = tbl_cnt; i > lo; i--) begin
					tbl_key[i] = tbl_key[i-1];
					tbl_idx[i] = tbl_idx[i-1];
					tbl_tag[i] = tbl_tag[i-1];
				end
				tbl_key[lo] = w.key;
				tbl_idx[lo] = w.entry_index;
				tbl_tag[lo] = w.entry_tag;
				tbl_cnt++;
			end
		end
		FN_FIND: begin
			// stops on the first probe that matches, not necessarily the
			// first of a run of duplicates
			while (lo < hi && !found) begin
				mid = (lo + hi) / 2;
				if ($signed(tbl_key[mid]) < $signed(w.key))
					lo = mid + 1;
				else if ($signed(tbl_key[mid]) > $signed(w.key))
					hi = mid;
				else
					found = 1'b1;
			end
			if (found) begin
				r.hit = 1'b1;
				r.slot = CNT_W'(mid);
				r.found_index = tbl_idx[mid];
				r.found_tag = tbl_tag[mid];
			end else begin
				r.slot = CNT_W'(lo);
			end
		end
		FN_CLEAR: begin
			tbl_cnt = 0;
		end
		default: begin
			// unknown func: nothing changes, only used is reported
		end
		endcase
		r.used = CNT_W'(tbl_cnt);
		return r;
	endfunction

	// Window of words during which neither side idles.
	function automatic bit steady();
		return words_in >= 120 && words_in < 240;
	endfunction

	// Key mix: a narrow band for duplicates and near misses, keys already
	// inserted, the signed extremes, and full-range values.
	function automatic logic signed [31:0] pick_key();
		int sel;
		int v;
		sel = $urandom_range(99);
		if (sel < 45) begin
			v = $urandom_range(40);
			return v - 20;
		end
		if (sel < 65 && key_hist.size() > 0)
			return key_hist[$urandom_range(key_hist.size() - 1)];
		if (sel < 75) begin
			case ($urandom_range(3))
			0: return KEY_MIN;
			1: return KEY_MIN + 1;
			2: return KEY_MAX;
			default: return KEY_MAX - 1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic push_word(logic [1:0] f, logic signed [31:0] k,
		logic signed [31:0] ix, logic [31:0] tg);
		op_t o;
		o.drain = 1'b0;
		o.word.func = f;
		o.word.key = k;
		o.word.entry_index = ix;
		o.word.entry_tag = tg;
		op_q.push_back(o);
		if (f == FN_INSERT)
			key_hist.push_back(k);
	endtask

	task automatic push_drain();
		op_t o;
		o.drain = 1'b1;
		o.word = '0;
		op_q.push_back(o);
	endtask

	// Mixed traffic with rare clears so the table grows to a useful depth.
	task automatic push_mixed(int n);
		int sel;
		repeat (n) begin
			sel = $urandom_range(99);
			if (sel < 48)
				push_word(FN_INSERT, pick_key(), $urandom, $urandom);
			else if (sel < 95)
				push_word(FN_FIND, pick_key(), $urandom, $urandom);
			else if (sel < 97)
				push_word(FN_CLEAR, $urandom, $urandom, $urandom);
			else
				push_word(FN_UNKNOWN, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Sender: valid and payload change on the falling edge. A word taken at
	// the last rising edge drops valid unless the next one goes out at once.
	always @(negedge clk) begin
		bit go;
		op_t head;
		if (arst_n) begin
			go = req_if.valid;
			if (words_in != words_seen) begin
				go = 1'b0;
				words_seen = words_in;
			end
			if (!go && op_q.size() > 0) begin
				head = op_q[0];
				if (head.drain) begin
					// hold off until the block owes nothing
					if (due_q.size() == 0)
						void'(op_q.pop_front());
				end else if (steady() || $urandom_range(99) >= IDLE_PCT) begin
					go = 1'b1;
					void'(op_q.pop_front());
					req_if.func <= head.word.func;
					req_if.key <= head.word.key;
					req_if.entry_index <= head.word.entry_index;
					req_if.entry_tag <= head.word.entry_tag;
				end
			end
			req_if.valid <= go;
		end
	end

	// Receiver back-pressure, also on the falling edge
	always @(negedge clk) begin
		if (arst_n)
			rsp_if.ready <= steady() || $urandom_range(99) >= IDLE_PCT;
	end

	// Monitor: both channels sampled on the rising edge. The result side is
	// handled first so a word taken in the same cycle never pairs with it.
	always @(posedge clk) begin
		rsp_t want;
		req_t w;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (due_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result word with nothing expected, used %0h",
						$time, rsp_if.used);
				end else begin
					want = due_q.pop_front();
					check_field("hit", 32'(want.hit), 32'(rsp_if.hit));
					check_field("slot", 32'(want.slot), 32'(rsp_if.slot));
					check_field("found_index", want.found_index, rsp_if.found_index);
					check_field("found_tag", want.found_tag, rsp_if.found_tag);
					check_field("status", 32'(want.status), 32'(rsp_if.status));
					check_field("used", 32'(want.used), 32'(rsp_if.used));
				end
			end
			if (req_if.valid && req_if.ready) begin
				w.func = req_if.func;
				w.key = req_if.key;
				w.entry_index = req_if.entry_index;
				w.entry_tag = req_if.entry_tag;
				due_q.push_back(table_step(w));
				words_in++;
			end
		end
	end

	initial begin
		int n_ins;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.func = FN_INSERT;
		req_if.key = '0;
		req_if.entry_index = '0;
		req_if.entry_tag = '0;
		rsp_if.ready = 1'b0;

		// Directed: empty table, signed extremes, payload extremes,
		// duplicates, hits and misses, unknown func, clear and reuse.
		push_word(FN_FIND, 0, 0, 0);
		push_word(FN_INSERT, 0, 1, 1);
		push_word(FN_INSERT, KEY_MIN, KEY_MIN, 32'h0000_0000);
		push_word(FN_INSERT, KEY_MAX, KEY_MAX, 32'hffff_ffff);
		push_word(FN_INSERT, 0, -1, 32'ha5a5_a5a5);    // duplicate key
		push_word(FN_INSERT, -1, 0, 32'h5a5a_5a5a);
		push_word(FN_INSERT, 0, 7, 32'h0000_0007);     // third copy
		push_word(FN_FIND, KEY_MIN, 0, 0);
		push_word(FN_FIND, KEY_MAX, 0, 0);
		push_word(FN_FIND, 0, 0, 0);
		push_word(FN_FIND, 1, 0, 0);                   // miss between entries
		push_word(FN_FIND, KEY_MIN + 1, 0, 0);
		push_word(FN_FIND, KEY_MAX - 1, 0, 0);
		push_word(FN_UNKNOWN, -1, -1, 32'hffff_ffff);
		push_word(FN_CLEAR, 0, 0, 0);
		push_word(FN_FIND, 0, 0, 0);                   // miss after clear
		push_word(FN_INSERT, 5, 32'sh1234_5678, 32'h8765_4321);
		push_word(FN_FIND, 5, 0, 0);
		push_word(FN_FIND, 4, 0, 0);
		push_drain();

		// Random traffic, with a drain in the middle
		push_mixed(100);
		push_drain();
		push_mixed(100);

		// Fill from empty to full, then push past full to get refusals;
		// finds are sprinkled in along the way.
		push_word(FN_CLEAR, $urandom, $urandom, $urandom);
		n_ins = 0;
		while (n_ins < TABLE_DEPTH + 6) begin
			if ($urandom_range(99) < 13) begin
				push_word(FN_FIND, pick_key(), $urandom, $urandom);
			end else begin
				push_word(FN_INSERT, pick_key(), $urandom, $urandom);
				n_ins++;
			end
		end
		push_word(FN_FIND, KEY_MIN, 0, 0);
		push_word(FN_FIND, KEY_MAX, 0, 0);
		push_word(FN_UNKNOWN, $urandom, $urandom, $urandom);
		push_word(FN_INSERT, KEY_MAX, $urandom, $urandom);
		push_word(FN_CLEAR, $urandom, $urandom, $urandom);
		push_drain();
		push_mixed(40);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (op_q.size() > 0 || req_if.valid || due_q.size() > 0)
			@(posedge clk);
		// stray words after the last expected one still get flagged
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("testbench: errors");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_req_if.sv
rtl/skt_rsp_if.sv
rtl/skt_ram.sv
rtl/skt_seq.sv
rtl/sorted_key_table_search_insert_core.sv
sim/testbench.sv
